// File: rtl/hyperplane_distance_sort_assert.svh
// assertion macros for the hyperplane distance sort block
`ifndef HYPERPLANE_DISTANCE_SORT_ASSERT_SVH
`define HYPERPLANE_DISTANCE_SORT_ASSERT_SVH
`ifndef SYNTHESIS
`define HDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define HDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/hds_pkg.sv
// shared constants and a saturation helper for the hyperplane distance sort block
`timescale 1ns / 1ps
package hds_pkg;
  localparam logic [1:0] ACT_NORMAL = 2'd0;
  localparam logic [1:0] ACT_OFFSET = 2'd1;
  localparam logic [1:0] ACT_POINT  = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;
  localparam logic [31:0] DIST_SAT    = 32'hFFFF_FFFE;
  localparam logic [31:0] DIST_UNUSED = 32'hFFFF_FFFF;
  localparam int FIELD_LIMIT = 16;

  // saturate a 32-bit signed request value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7FFF;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage

// File: rtl/hds_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module hds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/hds_mac.sv
// shared multiply-accumulate unit with rounding, offset and saturation
`timescale 1ns / 1ps
`include "hyperplane_distance_sort_assert.svh"
module hds_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               mul_en,
  input  logic signed [15:0] nrm,
  input  logic signed [15:0] pnt,
  input  logic               acc_en,
  input  logic               fin,
  input  logic signed [31:0] offset,
  output logic [31:0]        dist_val
);
  logic signed [31:0] prod_r;
  logic signed [39:0] acc_r, acc_nxt;
  logic               any_r, any_nxt;
  logic               pany_r;
  logic signed [41:0] rnd;
  logic signed [42:0] tot;
  logic        [42:0] mag;

  // multiply stage then accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r  <= 1'b0;
      pany_r <= 1'b0;
    end else begin
      if (mul_en) pany_r <= (nrm != 16'sd0);
      any_r <= any_nxt;
    end
    if (mul_en) prod_r <= nrm * pnt;
    acc_r <= acc_nxt;
  end

  always_comb begin
    acc_nxt = acc_r;
    any_nxt = any_r;
    if (clr) begin
      acc_nxt = '0;
      any_nxt = 1'b0;
    end else if (acc_en) begin
      acc_nxt = acc_r + 40'(prod_r);
      any_nxt = any_r | pany_r;
    end
  end

  // round to q16.16 (floor after adding half), add offset, magnitude, saturate
  always_comb begin
    rnd  = (42'(acc_r) + 42'sd32) >>> 6;
    tot  = 43'(rnd) + 43'(offset);
    mag  = tot[42] ? 43'(-tot) : 43'(tot);
    if (!any_r) dist_val = hds_pkg::DIST_UNUSED;
    else if (mag > 43'(hds_pkg::DIST_SAT)) dist_val = hds_pkg::DIST_SAT;
    else dist_val = mag[31:0];
  end

  `HDS_ASSERT_NEXT(a_clr_acc, clk, rst_n, clr, acc_r == 40'sd0, "clear did not zero acc")
  `HDS_ASSERT_NEXT(a_clr_any, clk, rst_n, clr, !any_r, "clear did not drop any flag")
  `HDS_ASSERT_IMPL(a_unused, clk, rst_n, fin && !any_r, dist_val == hds_pkg::DIST_UNUSED,
    "zero normal not marked")
endmodule

// File: rtl/hyperplane_distance_sort.sv
// top level: tables, sequencer, shared mac and insertion sort
// channel | direction | ports
// in      | request   | start, busy, in_action, in_plane_number, in_coord_number, in_value
// out     | result    | out_valid, out_plane_id, out_distance, out_last
// cfg     | write     | cfg_valid, cfg_ready, cfg_index, cfg_data
// the last point coordinate starts a run: each plane goes through the shared
// multiplier, then the shift-insert sort loop, and the planes are emitted in
// sorted order once all are inserted
// synchronous active-low reset clears control state only; tables need writing first
// results leave one per cycle under out_valid; the receiver cannot stall
`timescale 1ns / 1ps
`include "hyperplane_distance_sort_assert.svh"
module hyperplane_distance_sort #(
  parameter int MAX_DIM    = 16,
  parameter int MAX_PLANES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_plane_number,
  input  logic [3:0]  in_coord_number,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [3:0]  out_plane_id,
  output logic [31:0] out_distance,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int NDEPTH = MAX_PLANES * MAX_DIM;
  localparam int NW = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
  localparam int DLIM = (MAX_DIM < hds_pkg::FIELD_LIMIT) ? MAX_DIM : hds_pkg::FIELD_LIMIT;
  localparam int PLIM = (MAX_PLANES < hds_pkg::FIELD_LIMIT) ? MAX_PLANES
                                                            : hds_pkg::FIELD_LIMIT;
  localparam int CW = PW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DRN  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  dim_cfg_r, pl_cfg_r;
  logic [4:0]  dim_c, np_c;
  logic [PW-1:0] plane_r, plane_nxt;
  logic [DW:0]   coord_r, coord_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [1:0]    drn_r, drn_nxt;
  logic [31:0]   dcur_r, dcur_nxt;
  logic [31:0]   sdist_r [MAX_PLANES];
  logic [3:0]    splane_r [MAX_PLANES];
  logic signed [15:0] point_r [MAX_DIM];
  logic [31:0]   offset_r [MAX_PLANES];
  logic [PW-1:0] emit_r, emit_nxt;

  logic          acc_go;
  logic          nram_we;
  logic [NW-1:0] nram_wa, nram_ra;
  logic [15:0]   nram_rd;
  logic          mul_en_r, acc_en_r, clr;
  logic [DW-1:0] pidx_r;
  logic [31:0]   plane_dist;
  logic          fin;
  logic          ins_shift;

  // clamp registers to valid counts
  always_comb begin
    dim_c = (dim_cfg_r == 5'd0) ? 5'd1 : (dim_cfg_r > 5'(DLIM)) ? 5'(DLIM) : dim_cfg_r;
    np_c  = (pl_cfg_r == 5'd0) ? 5'd1 : (pl_cfg_r > 5'(PLIM)) ? 5'(PLIM) : pl_cfg_r;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign acc_go    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_cfg_r <= 5'd16;
      pl_cfg_r  <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == 1'b0) dim_cfg_r <= cfg_data;
      else pl_cfg_r <= cfg_data;
    end
  end

  // normal table memory
  assign nram_we = acc_go && in_action == hds_pkg::ACT_NORMAL &&
                   32'(in_plane_number) < 32'(MAX_PLANES) &&
                   32'(in_coord_number) < 32'(MAX_DIM);
  assign nram_wa = NW'(32'(in_plane_number) * MAX_DIM + 32'(in_coord_number));
  assign nram_ra = NW'(32'(plane_r) * MAX_DIM + 32'(coord_r));

  hds_ram #(.WIDTH(16), .DEPTH(NDEPTH)) u_nram (
    .clk(clk), .we(nram_we), .waddr(nram_wa),
    .wdata(hds_pkg::sat16(in_value)), .raddr(nram_ra), .rdata(nram_rd)
  );

  // offset and point stores
  always_ff @(posedge clk) begin
    if (acc_go && in_action == hds_pkg::ACT_OFFSET &&
        32'(in_plane_number) < 32'(MAX_PLANES))
      offset_r[PW'(in_plane_number)] <= in_value;
    if (acc_go && in_action == hds_pkg::ACT_POINT &&
        32'(in_coord_number) < 32'(MAX_DIM))
      point_r[DW'(in_coord_number)] <= hds_pkg::sat16(in_value);
  end

  // ram data lands the cycle after its address, aligned with mul enable; acc enable next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_en_r <= 1'b0;
      acc_en_r <= 1'b0;
    end else begin
      mul_en_r <= (state_r == S_MAC);
      acc_en_r <= mul_en_r;
    end
    pidx_r <= coord_r[DW-1:0];
  end

  assign clr = (state_r == S_IDLE) || (state_r == S_INS);
  assign fin = (state_r == S_DRN) && (drn_r == 2'd2);

  hds_mac u_mac (
    .clk(clk), .rst_n(rst_n), .clr(clr), .mul_en(mul_en_r),
    .nrm(nram_rd), .pnt(point_r[pidx_r]),
    .acc_en(acc_en_r),
    .fin(fin), .offset(offset_r[plane_r]), .dist_val(plane_dist)
  );

  assign ins_shift = (state_r == S_INS) && (pos_r != '0) &&
                     (sdist_r[PW'(pos_r - 1'b1)] > dcur_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    coord_nxt = coord_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    drn_nxt   = drn_r;
    dcur_nxt  = dcur_r;
    emit_nxt  = emit_r;
    case (state_r)
      S_IDLE: begin
        if (acc_go && in_action == hds_pkg::ACT_POINT &&
            32'(in_coord_number) < 32'(MAX_DIM) &&
            5'(in_coord_number) == dim_c - 5'd1) begin
          state_nxt = S_MAC;
          plane_nxt = '0;
          coord_nxt = '0;
          cnt_nxt   = '0;
        end
      end
      S_MAC: begin
        coord_nxt = coord_r + 1'b1;
        if (5'(coord_r) == dim_c - 5'd1) begin
          state_nxt = S_DRN;
          drn_nxt   = 2'd0;
        end
      end
      S_DRN: begin
        drn_nxt = drn_r + 2'd1;
        if (drn_r == 2'd2) begin
          state_nxt = S_INS;
          dcur_nxt  = plane_dist;
          pos_nxt   = cnt_r;
        end
      end
      S_INS: begin
        if (ins_shift) pos_nxt = pos_r - 1'b1;
        else begin
          cnt_nxt = cnt_r + 1'b1;
          if (5'(cnt_r) + 5'd1 == np_c) begin
            state_nxt = S_EMIT;
            emit_nxt  = '0;
          end else begin
            state_nxt = S_MAC;
            plane_nxt = plane_r + 1'b1;
            coord_nxt = '0;
          end
        end
      end
      S_EMIT: begin
        emit_nxt = emit_r + 1'b1;
        if (5'(emit_r) + 5'd1 == np_c) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    plane_r <= plane_nxt;
    coord_r <= coord_nxt;
    cnt_r   <= cnt_nxt;
    pos_r   <= pos_nxt;
    drn_r   <= drn_nxt;
    dcur_r  <= dcur_nxt;
    emit_r  <= emit_nxt;
  end

  // sorted list: shift one entry up or drop in the new one
  always_ff @(posedge clk) begin
    if (state_r == S_INS) begin
      if (ins_shift) begin
        sdist_r[PW'(pos_r)]  <= sdist_r[PW'(pos_r - 1'b1)];
        splane_r[PW'(pos_r)] <= splane_r[PW'(pos_r - 1'b1)];
      end else begin
        sdist_r[PW'(pos_r)]  <= dcur_r;
        splane_r[PW'(pos_r)] <= 4'(plane_r);
      end
    end
  end

  // result outputs
  assign out_valid    = (state_r == S_EMIT);
  assign out_plane_id = splane_r[emit_r];
  assign out_distance = sdist_r[emit_r];
  assign out_last     = out_valid && (5'(emit_r) + 5'd1 == np_c);

  `HDS_ASSERT_IMPL(a_last_ends, clk, rst_n, out_last, state_nxt == S_IDLE,
    "last result without return to idle")
  `HDS_ASSERT_IMPL(a_cfg_idle, clk, rst_n, cfg_ready, !busy, "config taken while busy")
  `HDS_ASSERT_IMPL(a_cnt_range, clk, rst_n, busy, 5'(cnt_r) <= np_c, "plane count overrun")
endmodule
